// ===== hw/rtl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, codes and the entry type.
// Used by the channel interfaces, the queue cell and the top level.
package spq_pkg;

   // Number of slots in the queue.
   localparam int Depth = 16;
   // Width of the occupancy count, wide enough to hold Depth itself.
   localparam int CntW = $clog2(Depth + 1);
   // Width of the fill field on the result channel.
   localparam int FillW = 5;

   localparam int PidW = 16;
   localparam int PrioW = 8;
   localparam int StatusW = 2;

   // Command codes.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP = 1'b1;

   // Status codes.
   localparam logic [StatusW-1:0] STATUS_OK = 2'd0;
   localparam logic [StatusW-1:0] STATUS_FULL = 2'd1;
   localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

   // One stored entry.
   typedef struct packed {
      logic [PidW-1:0] pid;
      logic [PrioW-1:0] prio;
   } entry_type;

   // Per-cycle control broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
      entry_type new_entry;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/spq_req_if.sv =====
// Request channel of the sorted priority queue: valid, ready and one item.
// Depends on spq_pkg for field widths.
interface spq_req_if
   import spq_pkg::*;
();
   logic valid;
   logic ready;
   logic command;
   logic [PidW-1:0] pid;
   logic [PrioW-1:0] priority_req;

   modport source (output valid, output command, output pid, output priority_req,
                   input ready);
   modport sink (input valid, input command, input pid, input priority_req,
                 output ready);
endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
// Response channel of the sorted priority queue: valid, ready and one item.
// Depends on spq_pkg for field widths.
interface spq_rsp_if
   import spq_pkg::*;
();
   logic valid;
   logic ready;
   logic [PidW-1:0] out_pid;
   logic [PrioW-1:0] out_priority;
   logic [StatusW-1:0] status;
   logic [FillW-1:0] fill;

   modport source (output valid, output out_pid, output out_priority, output status,
                   output fill, input ready);
   modport sink (input valid, input out_pid, input out_priority, input status,
                 input fill, output ready);
endinterface

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and trades with neighbors.
// Depends on spq_pkg for the entry and control types.
module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         left_keep,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output logic         keep,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // An occupied slot whose priority is not above the new one stays put on a push.
   assign keep = occupied && (entry_ff.prio <= ctl.new_entry.prio);

   // On a push the first non-keeping slot takes the new entry and later ones
   // take their left neighbor; on a pop every slot takes its right neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctl.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a chain of cells, one entry per cell.
// A result lands in the response register in the cycle after its item is accepted.
// Throughput: one item per cycle when not stalled; every cell compares and shifts.
// Reset clears the occupancy count and the response valid; slot contents
// are not reset and are only read below the count.
module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [PidW-1:0] rsp_pid_ff;
   logic [PidW-1:0] rsp_pid_in;
   logic [PrioW-1:0] rsp_prio_ff;
   logic [PrioW-1:0] rsp_prio_in;
   logic [StatusW-1:0] rsp_status_ff;
   logic [StatusW-1:0] rsp_status_in;
   logic [FillW-1:0] rsp_fill_ff;
   logic [FillW-1:0] rsp_fill_in;

   logic accept;
   logic full;
   logic empty;
   logic do_push;
   logic do_pop;
   cell_ctl_type ctl;
   logic [Depth-1:0] occupied;
   logic [Depth-1:0] cell_keep;
   entry_type cell_entry [Depth];

   // A new item enters whenever the response register is free or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   assign full = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign do_push = accept && (req_ch.command == CMD_PUSH) && !full;
   assign do_pop = accept && (req_ch.command == CMD_POP) && !empty;

   assign ctl.push = do_push;
   assign ctl.pop = do_pop;
   assign ctl.new_entry.pid = req_ch.pid;
   assign ctl.new_entry.prio = req_ch.priority_req;

   // Chain of cells; the head sees a keeping left neighbor, the tail holds on pop.
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic left_keep;

      assign occupied[i] = (CntW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_entry = ctl.new_entry;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == Depth - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied[i]),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i])
      );
   end

   // Occupancy count and response register.
   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CntW'(1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pid_in = rsp_pid_ff;
      rsp_prio_in = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in = rsp_fill_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_pid_in = '0;
         rsp_prio_in = '0;
         rsp_status_in = STATUS_OK;
         rsp_fill_in = FillW'(count_in);
         if (req_ch.command == CMD_PUSH) begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end
         end else if (empty) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_pid_in = cell_entry[0].pid;
            rsp_prio_in = cell_entry[0].prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pid_ff <= rsp_pid_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_pid = rsp_pid_ff;
   assign rsp_ch.out_priority = rsp_prio_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.fill = rsp_fill_ff;

   // The count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("occupancy count exceeds queue depth");

   // A refused push leaves the count at full.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.command == CMD_PUSH) && full |=> count_ff == CntW'(Depth))
      else $error("refused push changed the occupancy");

   // A successful pop takes exactly one entry away.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("pop did not decrement the occupancy");

   // The two front entries stay in priority order.
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntW'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
      else $error("front entries out of priority order");

endmodule
